>>> rtl/sct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source character tokenizer package
// Token kinds, character codes, lexer mode encoding and the character
// classification functions used by the lexer front end.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int KIND_W      = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_NEWLINE = 5'd0,
      KIND_PLUS    = 5'd1,
      KIND_DASH    = 5'd2,
      KIND_STAR    = 5'd3,
      KIND_SLASH   = 5'd4,
      KIND_GT      = 5'd5,
      KIND_GTE     = 5'd6,
      KIND_LT      = 5'd7,
      KIND_LTE     = 5'd8,
      KIND_NOT     = 5'd9,
      KIND_IDENT   = 5'd10,
      KIND_COLON   = 5'd11,
      KIND_DCOLON  = 5'd12,
      KIND_LBRACE  = 5'd13,
      KIND_RBRACE  = 5'd14,
      KIND_LPAREN  = 5'd15,
      KIND_RPAREN  = 5'd16,
      KIND_AND     = 5'd17,
      KIND_OR      = 5'd18,
      KIND_ASSIGN  = 5'd19,
      KIND_COMMA   = 5'd20,
      KIND_ARROW   = 5'd21,
      KIND_DOT     = 5'd22,
      KIND_QUOTE   = 5'd23,
      KIND_LSQUARE = 5'd24,
      KIND_RSQUARE = 5'd25,
      KIND_INVALID = 5'd26
   } tok_kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'b0001,
      MODE_IDENT   = 4'b0010,
      MODE_HOLD    = 4'b0100,
      MODE_COMMENT = 4'b1000
   } lex_mode_type;

   typedef struct packed {
      logic         hit;
      tok_kind_type kind;
   } kind_lookup_type;

   // one queue entry: present, and carrying a second token
   typedef struct packed {
      logic valid;
      logic two;
   } ent_ctl_type;

   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NOT     = 8'h21;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_APOS    = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UZ      = 8'h5A;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LZ      = 8'h7A;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   function automatic kind_lookup_type char_kind(input logic [7:0] c);
      kind_lookup_type r;
      r.hit  = 1'b1;
      r.kind = KIND_INVALID;
      case (c)
         CH_PLUS:    r.kind = KIND_PLUS;
         CH_DASH:    r.kind = KIND_DASH;
         CH_STAR:    r.kind = KIND_STAR;
         CH_SLASH:   r.kind = KIND_SLASH;
         CH_GT:      r.kind = KIND_GT;
         CH_LT:      r.kind = KIND_LT;
         CH_NOT:     r.kind = KIND_NOT;
         CH_COLON:   r.kind = KIND_COLON;
         CH_LBRACE:  r.kind = KIND_LBRACE;
         CH_RBRACE:  r.kind = KIND_RBRACE;
         CH_LPAREN:  r.kind = KIND_LPAREN;
         CH_RPAREN:  r.kind = KIND_RPAREN;
         CH_AMP:     r.kind = KIND_INVALID;
         CH_PIPE:    r.kind = KIND_INVALID;
         CH_EQ:      r.kind = KIND_ASSIGN;
         CH_COMMA:   r.kind = KIND_COMMA;
         CH_DOT:     r.kind = KIND_DOT;
         CH_DQUOTE:  r.kind = KIND_QUOTE;
         CH_LSQUARE: r.kind = KIND_LSQUARE;
         CH_RSQUARE: r.kind = KIND_RSQUARE;
         default:    r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic kind_lookup_type pair_kind(input logic [7:0] h, input logic [7:0] c);
      kind_lookup_type r;
      r.hit  = 1'b1;
      r.kind = KIND_INVALID;
      priority if (h == CH_COLON && c == CH_COLON) r.kind = KIND_DCOLON;
      else if (h == CH_DASH && c == CH_GT)         r.kind = KIND_ARROW;
      else if (h == CH_AMP && c == CH_AMP)         r.kind = KIND_AND;
      else if (h == CH_PIPE && c == CH_PIPE)       r.kind = KIND_OR;
      else if (h == CH_LT && c == CH_EQ)           r.kind = KIND_LTE;
      else if (h == CH_GT && c == CH_EQ)           r.kind = KIND_GTE;
      else                                         r.hit  = 1'b0;
      return r;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
             (c >= CH_LA && c <= CH_LZ);
   endfunction

   function automatic logic is_holder(input logic [7:0] c);
      return c == CH_COLON || c == CH_DASH || c == CH_AMP || c == CH_PIPE ||
             c == CH_LT || c == CH_GT || c == CH_SLASH;
   endfunction

   function automatic logic ends_ident(input logic [7:0] c);
      kind_lookup_type k;
      k = char_kind(c);
      return c == CH_SPACE || c == CH_PERCENT || c == CH_APOS || c == CH_NL || k.hit;
   endfunction

endpackage

>>> rtl/sct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer lexer front end
// Classifies one character per cycle while accept is high, keeps the lexer
// mode, held operator, open identifier and line/column counters, and emits a
// bundle of up to two tokens per transaction towards the token queue.
// ----------------------------------------------------------------------------
module sct_front #(
   parameter int LINE_WIDTH = 16,
   parameter int COL_WIDTH  = 16,
   parameter int LEN_WIDTH  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        req_type,
   input  logic [7:0]                  req_ch,
   output sct_pkg::ent_ctl_type        ent_ctl,
   output logic [sct_pkg::KIND_W-1:0]  ent_kind0,
   output logic [COL_WIDTH-1:0]        ent_col0,
   output logic [LEN_WIDTH-1:0]        ent_len0,
   output logic [sct_pkg::KIND_W-1:0]  ent_kind1,
   output logic [COL_WIDTH-1:0]        ent_col1,
   output logic [LINE_WIDTH-1:0]       ent_line
);
   import sct_pkg::*;

   lex_mode_type          mode_ff, mode_in;
   logic [7:0]            held_char_ff, held_char_in;
   logic [COL_WIDTH-1:0]  held_col_ff, held_col_in;
   logic [COL_WIDTH-1:0]  start_col_ff, start_col_in;
   logic [LEN_WIDTH-1:0]  count_ff, count_in;
   logic [LINE_WIDTH-1:0] line_ff, line_in;
   logic [COL_WIDTH-1:0]  col_ff, col_in;

   logic [COL_WIDTH-1:0]  col_inc;
   logic [LINE_WIDTH-1:0] line_inc;
   logic [LEN_WIDTH-1:0]  count_inc;
   kind_lookup_type       ch_look, held_look, pair_look;

   logic                  pre_v, b_v, proc_en, proc_ident;
   tok_kind_type          pre_kind, b_kind;
   logic [COL_WIDTH-1:0]  pre_col, b_col;
   logic [LEN_WIDTH-1:0]  pre_len;

   assign col_inc   = (col_ff == '1) ? col_ff : col_ff + COL_WIDTH'(1);
   assign line_inc  = (line_ff == '1) ? line_ff : line_ff + LINE_WIDTH'(1);
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + LEN_WIDTH'(1);
   assign ch_look   = char_kind(req_ch);
   assign held_look = char_kind(held_char_ff);
   assign pair_look = pair_kind(held_char_ff, req_ch);

   always_comb begin
      mode_in      = mode_ff;
      held_char_in = held_char_ff;
      held_col_in  = held_col_ff;
      start_col_in = start_col_ff;
      count_in     = count_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      pre_v        = 1'b0;
      pre_kind     = KIND_NEWLINE;
      pre_col      = '0;
      pre_len      = '0;
      b_v          = 1'b0;
      b_kind       = KIND_NEWLINE;
      b_col        = '0;
      proc_en      = 1'b0;
      proc_ident   = 1'b0;

      if (accept && req_type) begin
         if (mode_ff == MODE_IDENT) begin
            pre_v    = 1'b1;
            pre_kind = KIND_IDENT;
            pre_col  = start_col_ff;
            pre_len  = count_ff;
         end else if (mode_ff == MODE_HOLD) begin
            pre_v    = 1'b1;
            pre_kind = held_look.kind;
            pre_col  = held_col_ff;
         end
         mode_in = MODE_IDLE;
      end else if (accept) begin
         col_in = col_inc;
         unique case (mode_ff)
            MODE_COMMENT: begin
               if (req_ch == CH_NL) begin
                  mode_in = MODE_IDLE;
                  line_in = line_inc;
                  col_in  = '0;
               end
            end
            MODE_HOLD: begin
               if (held_char_ff == CH_SLASH && req_ch == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else if (pair_look.hit) begin
                  pre_v    = 1'b1;
                  pre_kind = pair_look.kind;
                  pre_col  = held_col_ff;
                  mode_in  = MODE_IDLE;
               end else begin
                  pre_v    = 1'b1;
                  pre_kind = held_look.kind;
                  pre_col  = held_col_ff;
                  mode_in  = MODE_IDLE;
                  proc_en  = 1'b1;
               end
            end
            MODE_IDENT: begin
               proc_en    = 1'b1;
               proc_ident = 1'b1;
            end
            default: begin
               proc_en = 1'b1;
            end
         endcase

         if (proc_en) begin
            if (is_alnum(req_ch)) begin
               if (proc_ident) begin
                  count_in = count_inc;
               end else begin
                  mode_in      = MODE_IDENT;
                  start_col_in = col_inc;
                  count_in     = LEN_WIDTH'(1);
               end
            end else if (!proc_ident || ends_ident(req_ch)) begin
               if (proc_ident) begin
                  pre_v    = 1'b1;
                  pre_kind = KIND_IDENT;
                  pre_col  = start_col_ff;
                  pre_len  = count_ff;
                  mode_in  = MODE_IDLE;
               end
               if (req_ch == CH_NL) begin
                  b_v     = 1'b1;
                  b_kind  = KIND_NEWLINE;
                  b_col   = col_inc;
                  line_in = line_inc;
                  col_in  = '0;
               end else if (is_holder(req_ch)) begin
                  mode_in      = MODE_HOLD;
                  held_char_in = req_ch;
                  held_col_in  = col_inc;
               end else if (ch_look.hit) begin
                  b_v    = 1'b1;
                  b_kind = ch_look.kind;
                  b_col  = col_inc;
               end
            end
         end
      end
   end

   assign ent_ctl.valid = pre_v | b_v;
   assign ent_ctl.two   = pre_v & b_v;
   assign ent_kind0     = pre_v ? pre_kind : b_kind;
   assign ent_col0      = pre_v ? pre_col : b_col;
   assign ent_len0      = pre_v ? pre_len : '0;
   assign ent_kind1     = b_kind;
   assign ent_col1      = b_col;
   assign ent_line      = line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         held_char_ff <= '0;
         held_col_ff  <= '0;
         start_col_ff <= '0;
         count_ff     <= '0;
         line_ff      <= LINE_WIDTH'(1);
         col_ff       <= '0;
      end else begin
         mode_ff      <= mode_in;
         held_char_ff <= held_char_in;
         held_col_ff  <= held_col_in;
         start_col_ff <= start_col_in;
         count_ff     <= count_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
      end
   end

endmodule

>>> rtl/sct_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer token queue and output serialiser
// Holds token bundles from the lexer and hands them out one token per
// transaction, marking the last token of each bundle.
// ----------------------------------------------------------------------------
module sct_back #(
   parameter int LINE_WIDTH = 16,
   parameter int COL_WIDTH  = 16,
   parameter int LEN_WIDTH  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sct_pkg::ent_ctl_type        ent_ctl,
   input  logic [sct_pkg::KIND_W-1:0]  ent_kind0,
   input  logic [COL_WIDTH-1:0]        ent_col0,
   input  logic [LEN_WIDTH-1:0]        ent_len0,
   input  logic [sct_pkg::KIND_W-1:0]  ent_kind1,
   input  logic [COL_WIDTH-1:0]        ent_col1,
   input  logic [LINE_WIDTH-1:0]       ent_line,
   output logic                        full,
   output logic                        empty,
   input  logic                        pop,
   output logic [sct_pkg::KIND_W-1:0]  rsp_tok_kind,
   output logic [LINE_WIDTH-1:0]       rsp_tok_line,
   output logic [COL_WIDTH-1:0]        rsp_tok_col,
   output logic [LEN_WIDTH-1:0]        rsp_ident_len,
   output logic                        rsp_last_of_run
);
   import sct_pkg::*;

   logic [KIND_W-1:0]     kind0_ff [QUEUE_DEPTH];
   logic [COL_WIDTH-1:0]  col0_ff  [QUEUE_DEPTH];
   logic [LEN_WIDTH-1:0]  len0_ff  [QUEUE_DEPTH];
   logic [KIND_W-1:0]     kind1_ff [QUEUE_DEPTH];
   logic [COL_WIDTH-1:0]  col1_ff  [QUEUE_DEPTH];
   logic [LINE_WIDTH-1:0] line_ff  [QUEUE_DEPTH];
   logic                  two_ff   [QUEUE_DEPTH];

   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  sel_ff, sel_in;
   logic                  pop_tok, pop_ent;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_tok = pop && !empty;
   assign pop_ent = pop_tok && (sel_ff || !two_ff[rd_ptr_ff]);

   assign rsp_tok_kind    = sel_ff ? kind1_ff[rd_ptr_ff] : kind0_ff[rd_ptr_ff];
   assign rsp_tok_col     = sel_ff ? col1_ff[rd_ptr_ff] : col0_ff[rd_ptr_ff];
   assign rsp_ident_len   = sel_ff ? '0 : len0_ff[rd_ptr_ff];
   assign rsp_tok_line    = line_ff[rd_ptr_ff];
   assign rsp_last_of_run = sel_ff || !two_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      sel_in    = sel_ff;
      if (ent_ctl.valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop_tok) begin
         sel_in = !pop_ent;
      end
      if (pop_ent) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      unique case ({ent_ctl.valid, pop_ent})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ent_ctl.valid) begin
         kind0_ff[wr_ptr_ff] <= ent_kind0;
         col0_ff[wr_ptr_ff]  <= ent_col0;
         len0_ff[wr_ptr_ff]  <= ent_len0;
         kind1_ff[wr_ptr_ff] <= ent_kind1;
         col1_ff[wr_ptr_ff]  <= ent_col1;
         line_ff[wr_ptr_ff]  <= ent_line;
         two_ff[wr_ptr_ff]   <= ent_ctl.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sel_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sel_ff    <= sel_in;
      end
   end

endmodule

>>> rtl/source_char_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source character tokenizer
// Lexer front end and token queue joined behind queue-style ports.
// ----------------------------------------------------------------------------
// One character or end-of-text marker is taken per clock while full is low;
// the lexer decides it in that same cycle and drops zero, one or two tokens
// into a four-entry bundle queue. Tokens leave one per clock while pop is high
// and empty is low, so a character that ends an identifier with an operator
// that is not held or with a newline costs two output transactions, and the
// input rate is set by the token rate once the queue fills: one character per
// cycle while characters average at most one token. A bundle is registered
// into the queue as its character is taken. last_of_run marks the final token
// of each character; an end-of-text marker flushes a held operator or an open
// identifier and keeps the line and column counts, which saturate.
module source_char_tokenizer_core #(
   parameter int LINE_WIDTH = 16,
   parameter int COL_WIDTH  = 16,
   parameter int LEN_WIDTH  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_type,
   input  logic [7:0]                  req_ch,
   output logic                        empty,
   input  logic                        pop,
   output logic [sct_pkg::KIND_W-1:0]  rsp_tok_kind,
   output logic [LINE_WIDTH-1:0]       rsp_tok_line,
   output logic [COL_WIDTH-1:0]        rsp_tok_col,
   output logic [LEN_WIDTH-1:0]        rsp_ident_len,
   output logic                        rsp_last_of_run
);
   import sct_pkg::*;

   ent_ctl_type           ent_ctl;
   logic [KIND_W-1:0]     ent_kind0, ent_kind1;
   logic [COL_WIDTH-1:0]  ent_col0, ent_col1;
   logic [LEN_WIDTH-1:0]  ent_len0;
   logic [LINE_WIDTH-1:0] ent_line;
   logic                  accept;

   assign accept = push && !full;

   sct_front #(
      .LINE_WIDTH (LINE_WIDTH),
      .COL_WIDTH  (COL_WIDTH),
      .LEN_WIDTH  (LEN_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_type),
      .req_ch    (req_ch),
      .ent_ctl   (ent_ctl),
      .ent_kind0 (ent_kind0),
      .ent_col0  (ent_col0),
      .ent_len0  (ent_len0),
      .ent_kind1 (ent_kind1),
      .ent_col1  (ent_col1),
      .ent_line  (ent_line)
   );

   sct_back #(
      .LINE_WIDTH (LINE_WIDTH),
      .COL_WIDTH  (COL_WIDTH),
      .LEN_WIDTH  (LEN_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .ent_ctl         (ent_ctl),
      .ent_kind0       (ent_kind0),
      .ent_col0        (ent_col0),
      .ent_len0        (ent_len0),
      .ent_kind1       (ent_kind1),
      .ent_col1        (ent_col1),
      .ent_line        (ent_line),
      .full            (full),
      .empty           (empty),
      .pop             (pop),
      .rsp_tok_kind    (rsp_tok_kind),
      .rsp_tok_line    (rsp_tok_line),
      .rsp_tok_col     (rsp_tok_col),
      .rsp_ident_len   (rsp_ident_len),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_second_token_follows: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_last_of_run) |=> (!empty && rsp_last_of_run))
      else $error("second token of a bundle missing");

   a_len_only_ident: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_ident_len != '0) |-> (rsp_tok_kind == KIND_IDENT))
      else $error("non-zero length on a non-identifier token");

   a_col_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_tok_col != '0))
      else $error("token column of zero");

endmodule
